// File: design/tsv_pkg.sv
package tsv_pkg;

  // Character positions within YYYY-MM-DDTHH:MM:SS.ffffff.
  localparam int unsigned PosW = 5;

  localparam logic [PosW-1:0] TsLength = 5'd26;
  localparam logic [PosW-1:0] PosLast  = 5'd25;
  localparam logic [PosW-1:0] PosMax   = 5'd31;

  localparam logic [PosW-1:0] PosYearStart  = 5'd0;
  localparam logic [PosW-1:0] PosYearEnd    = 5'd3;
  localparam logic [PosW-1:0] PosDash0      = 5'd4;
  localparam logic [PosW-1:0] PosMonthStart = 5'd5;
  localparam logic [PosW-1:0] PosMonthEnd   = 5'd6;
  localparam logic [PosW-1:0] PosDash1      = 5'd7;
  localparam logic [PosW-1:0] PosDayStart   = 5'd8;
  localparam logic [PosW-1:0] PosDayEnd     = 5'd9;
  localparam logic [PosW-1:0] PosTee        = 5'd10;
  localparam logic [PosW-1:0] PosHourStart  = 5'd11;
  localparam logic [PosW-1:0] PosHourEnd    = 5'd12;
  localparam logic [PosW-1:0] PosColon0     = 5'd13;
  localparam logic [PosW-1:0] PosMinStart   = 5'd14;
  localparam logic [PosW-1:0] PosMinEnd     = 5'd15;
  localparam logic [PosW-1:0] PosColon1     = 5'd16;
  localparam logic [PosW-1:0] PosSecStart   = 5'd17;
  localparam logic [PosW-1:0] PosSecEnd     = 5'd18;
  localparam logic [PosW-1:0] PosDot        = 5'd19;
  localparam logic [PosW-1:0] PosFracStart  = 5'd20;

  localparam int unsigned FieldW = 20;
  localparam int unsigned MonthW = 7;

  localparam logic [FieldW-1:0] YearLimit  = 20'd10000;
  localparam logic [FieldW-1:0] MonthLimit = 20'd13;
  localparam logic [FieldW-1:0] HourLimit  = 20'd24;
  localparam logic [FieldW-1:0] SixtyLimit = 20'd60;
  localparam logic [FieldW-1:0] FracLimit  = 20'd1000000;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharDash  = 8'h2d;
  localparam logic [7:0] CharColon = 8'h3a;
  localparam logic [7:0] CharDot   = 8'h2e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       is_last;
  } tsv_item_t;

  // Exclusive upper bound of the day for a month of 1 to 12; no leap years.
  function automatic logic [5:0] day_limit(input logic [3:0] month);
    logic [5:0] lim;
    case (month)
      4'd2:                      lim = 6'd29;
      4'd4, 4'd6, 4'd9, 4'd11:   lim = 6'd31;
      default:                   lim = 6'd32;
    endcase
    return lim;
  endfunction

endpackage

// File: design/tsv_input_stage.sv
module tsv_input_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tsv_pkg::tsv_item_t item_i,
  input  logic               out_free_i,
  output logic               fire_o,
  output tsv_pkg::tsv_item_t item_o
);
  import tsv_pkg::*;

  logic      valid_q;
  logic      valid_d;
  tsv_item_t item_q;
  logic      take;

  // A byte that ends a string may only move on when the result register is free.
  assign fire_o     = valid_q && (!item_q.is_last || out_free_i);
  assign in_stall_o = valid_q && !fire_o;
  assign take       = in_valid_i && !in_stall_o;
  assign valid_d    = take ? 1'b1 : (fire_o ? 1'b0 : valid_q);
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
  end

endmodule

// File: design/tsv_check_core.sv
module tsv_check_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  tsv_pkg::tsv_item_t item_i,
  output logic               pass_o
);
  import tsv_pkg::*;

  logic [PosW-1:0]   pos_q, pos_d;
  logic              ok_q, ok_d;
  logic [FieldW-1:0] field_q, field_d;
  logic [MonthW-1:0] month_q, month_d;

  logic [PosW-1:0]   p;
  logic              ok;
  logic              is_digit;
  logic [3:0]        digit;
  logic              field_start;
  logic [FieldW-1:0] base;
  logic [FieldW-1:0] acc;
  logic [FieldW-1:0] fv;
  logic [MonthW-1:0] mv;

  assign p           = pos_q;
  assign is_digit    = (item_i.text_byte >= CharZero) && (item_i.text_byte <= CharNine);
  assign digit       = item_i.text_byte[3:0];
  assign field_start = (p == PosYearStart) || (p == PosMonthStart) || (p == PosDayStart) ||
                       (p == PosHourStart) || (p == PosMinStart) || (p == PosSecStart) ||
                       (p == PosFracStart);
  assign base        = field_start ? '0 : field_q;
  assign acc         = {base[FieldW-4:0], 3'b000} + {base[FieldW-2:0], 1'b0} +
                       {{(FieldW-4){1'b0}}, digit};

  always_comb begin
    ok = ok_q;
    fv = field_q;
    mv = month_q;
    if (p >= TsLength) begin
      ok = 1'b0;
    end else begin
      case (p)
        PosDash0, PosDash1: begin
          if (item_i.text_byte != CharDash) ok = 1'b0;
        end
        PosColon0, PosColon1: begin
          if (item_i.text_byte != CharColon) ok = 1'b0;
        end
        PosDot: begin
          if (item_i.text_byte != CharDot) ok = 1'b0;
        end
        PosTee: begin
          // The date/time separator is deliberately left unchecked.
        end
        default: begin
          if (!is_digit) begin
            ok = 1'b0;
          end else begin
            fv = acc;
          end
          case (p)
            PosYearEnd: begin
              if (fv >= YearLimit) ok = 1'b0;
            end
            PosMonthEnd: begin
              mv = fv[MonthW-1:0];
              if (fv < 20'd1 || fv >= MonthLimit) ok = 1'b0;
            end
            PosDayEnd: begin
              if (month_q < 7'd1 || month_q > 7'd12) begin
                ok = 1'b0;
              end else if (fv < 20'd1 ||
                           fv >= {14'd0, day_limit(month_q[3:0])}) begin
                ok = 1'b0;
              end
            end
            PosHourEnd: begin
              if (fv >= HourLimit) ok = 1'b0;
            end
            PosMinEnd, PosSecEnd: begin
              if (fv >= SixtyLimit) ok = 1'b0;
            end
            PosLast: begin
              if (fv >= FracLimit) ok = 1'b0;
            end
            default: begin
            end
          endcase
        end
      endcase
    end
  end

  assign pass_o = ok && (p == PosLast);

  always_comb begin
    if (item_i.is_last) begin
      pos_d   = '0;
      ok_d    = 1'b1;
      field_d = '0;
      month_d = '0;
    end else begin
      pos_d   = (pos_q < PosMax) ? pos_q + 5'd1 : pos_q;
      ok_d    = ok;
      field_d = fv;
      month_d = mv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      ok_q    <= 1'b1;
      field_q <= '0;
      month_q <= '0;
    end else if (fire_i) begin
      pos_q   <= pos_d;
      ok_q    <= ok_d;
      field_q <= field_d;
      month_q <= month_d;
    end
  end

endmodule

// File: design/tsv_output_stage.sv
module tsv_output_stage (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  logic pass_i,
  output logic out_free_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic format_ok_o
);
  import tsv_pkg::*;

  logic valid_q, valid_d;
  logic ok_q;

  assign out_free_o  = !valid_q || !out_stall_i;
  assign valid_d     = load_i ? 1'b1 : (out_stall_i ? valid_q : 1'b0);
  assign out_valid_o = valid_q;
  assign format_ok_o = ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ok_q <= pass_i;
    end
  end

endmodule

// File: design/timestamp_string_validator.sv
// Channel  | Direction | Handshake                | Payload
// ---------+-----------+--------------------------+------------------------
// input    | in        | in_valid_i, in_stall_o   | text_byte_i, is_last_i
// result   | out       | out_valid_o, out_stall_i | format_ok_o
//
// One byte is taken every cycle unless input is stalled; the per-byte digit test,
// times-ten accumulate and range compare sit between the input register and the
// checker state. The pass/fail result is loaded into the result register by the
// clock edge that moves the final byte on from the input register.
// Reset clears the position counter and checker state; no clearing pass is needed.
// Input is stalled only while the byte ending a string waits for a stalled result.
module timestamp_string_validator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  input  logic       is_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       format_ok_o
);
  import tsv_pkg::*;

  tsv_item_t in_item;
  tsv_item_t cur_item;
  logic      fire;
  logic      out_free;
  logic      pass;

  assign in_item.text_byte = text_byte_i;
  assign in_item.is_last   = is_last_i;

  tsv_input_stage u_input (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .out_free_i (out_free),
    .fire_o     (fire),
    .item_o     (cur_item)
  );

  tsv_check_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (cur_item),
    .pass_o (pass)
  );

  tsv_output_stage u_output (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire && cur_item.is_last),
    .pass_i      (pass),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .format_ok_o (format_ok_o)
  );

endmodule

// File: design/tsv_props.sv
module tsv_props (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] text_byte_i,
  input logic       is_last_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       format_ok_o
);
  import tsv_pkg::*;

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(format_ok_o))
    else $error("stalled result changed");

  // A stalled input transaction is held unchanged by the sender.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(text_byte_i) && $stable(is_last_i))
    else $error("stalled input changed");

  // Input back-pressure only ever comes from a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  // The byte ending a string yields a result once the result register is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && is_last_i) ##1 (!out_valid_o || !out_stall_i)
      |=> out_valid_o)
    else $error("final byte produced no result");

endmodule

bind timestamp_string_validator tsv_props u_tsv_props (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .text_byte_i (text_byte_i),
  .is_last_i   (is_last_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .format_ok_o (format_ok_o)
);

// File: dv/timestamp_string_validator_tb.sv
`timescale 1ns / 1ps

module timestamp_string_validator_tb;
  import tsv_pkg::*;

  typedef struct {
    logic [7:0]  ch;
    logic        last;
    int unsigned gap;
    bit          drain;
  } text_beat_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  logic [7:0] text_byte_i = 8'h00;
  logic       is_last_i   = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       format_ok_o;

  timestamp_string_validator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .text_byte_i (text_byte_i),
    .is_last_i   (is_last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .format_ok_o (format_ok_o)
  );

  // Stimulus and expected verdicts.
  text_beat_t beat_q[$];
  logic       verdict_q[$];

  // Checker state, mirroring what the block keeps between bytes.
  logic [PosW-1:0]   chk_pos   = '0;
  logic              chk_ok    = 1'b1;
  logic [FieldW-1:0] chk_acc   = '0;
  logic [MonthW-1:0] chk_month = '0;

  // String under construction.
  logic [7:0] str_buf [0:47];
  int         str_len;
  int         yr, mon, dy, hr, mnt, sec, frac;

  int unsigned queued_beats = 0;
  int unsigned strings_built = 0;
  int unsigned bytes_taken = 0;
  int unsigned results_seen = 0;
  int unsigned good_verdicts = 0;
  int unsigned bad_verdicts = 0;
  int unsigned mismatches = 0;

  int unsigned hold_cnt = 0;
  int unsigned stall_cnt = 0;
  bit          calm_rx = 1'b0;
  text_beat_t  beat;
  logic        verdict;
  logic        want;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int month_days(input int m);
    int n;
    case (m)
      2:             n = 28;
      4, 6, 9, 11:   n = 30;
      default:       n = 31;
    endcase
    return n;
  endfunction

  // Consumes one byte; returns 1 when the byte closes a string, with its verdict.
  function automatic bit advance_checker(input logic [7:0] ch, input logic last,
                                         output logic pass);
    logic [PosW-1:0]   p;
    logic              ok;
    logic [FieldW-1:0] base;
    p    = chk_pos;
    ok   = chk_ok;
    pass = 1'b0;
    if (p >= TsLength) begin
      ok = 1'b0;
    end else begin
      case (p)
        PosDash0, PosDash1: if (ch != CharDash) ok = 1'b0;
        PosColon0, PosColon1: if (ch != CharColon) ok = 1'b0;
        PosDot: if (ch != CharDot) ok = 1'b0;
        PosTee: ;
        default: begin
          // A non-digit leaves the accumulated value untouched.
          if (ch < CharZero || ch > CharNine) begin
            ok = 1'b0;
          end else begin
            case (p)
              PosYearStart, PosMonthStart, PosDayStart, PosHourStart,
              PosMinStart, PosSecStart, PosFracStart: base = '0;
              default: base = chk_acc;
            endcase
            chk_acc = base * 20'd10 + {12'd0, ch - CharZero};
          end
          case (p)
            PosYearEnd: if (chk_acc >= YearLimit) ok = 1'b0;
            PosMonthEnd: begin
              chk_month = chk_acc[MonthW-1:0];
              if (chk_acc < 20'd1 || chk_acc >= MonthLimit) ok = 1'b0;
            end
            PosDayEnd: begin
              if (chk_month < 7'd1 || chk_month > 7'd12) begin
                ok = 1'b0;
              end else if (chk_acc < 20'd1 ||
                           int'(chk_acc) > month_days(int'(chk_month))) begin
                ok = 1'b0;
              end
            end
            PosHourEnd: if (chk_acc >= HourLimit) ok = 1'b0;
            PosMinEnd, PosSecEnd: if (chk_acc >= SixtyLimit) ok = 1'b0;
            PosLast: if (chk_acc >= FracLimit) ok = 1'b0;
            default: ;
          endcase
        end
      endcase
    end
    chk_ok = ok;
    if (chk_pos != PosMax) chk_pos = chk_pos + 1'b1;
    if (last) begin
      pass      = ok && (p == PosLast);
      chk_pos   = '0;
      chk_ok    = 1'b1;
      chk_acc   = '0;
      chk_month = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int pick(input int lo, input int hi);
    int r;
    r = $urandom_range(9, 0);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return $urandom_range(hi, lo);
  endfunction

  task automatic put_digits(input int at, input int n, input int value);
    int v;
    v = value;
    for (int i = n - 1; i >= 0; i--) begin
      str_buf[at + i] = 8'(CharZero + v % 10);
      v = v / 10;
    end
  endtask

  task automatic compose_timestamp();
    put_digits(int'(PosYearStart), 4, yr);
    str_buf[PosDash0] = CharDash;
    put_digits(int'(PosMonthStart), 2, mon);
    str_buf[PosDash1] = CharDash;
    put_digits(int'(PosDayStart), 2, dy);
    str_buf[PosTee] = "T";
    put_digits(int'(PosHourStart), 2, hr);
    str_buf[PosColon0] = CharColon;
    put_digits(int'(PosMinStart), 2, mnt);
    str_buf[PosColon1] = CharColon;
    put_digits(int'(PosSecStart), 2, sec);
    str_buf[PosDot] = CharDot;
    put_digits(int'(PosFracStart), 6, frac);
    str_len = int'(TsLength);
  endtask

  task automatic draw_timestamp();
    yr   = pick(0, 9999);
    mon  = pick(1, 12);
    dy   = pick(1, month_days(mon));
    hr   = pick(0, 23);
    mnt  = pick(0, 59);
    sec  = pick(0, 59);
    frac = pick(0, 999999);
    compose_timestamp();
    if ($urandom_range(3, 0) == 0) str_buf[PosTee] = 8'($urandom_range(255, 0));
  endtask

  task automatic spoil_timestamp(input int kind);
    int pos;
    int n;
    case (kind)
      0: str_buf[$urandom_range(25, 0)] = 8'($urandom_range(255, 0));
      1: begin
        mon = $urandom_range(1, 0) ? 0 : $urandom_range(99, 13);
        compose_timestamp();
      end
      2: begin
        // Includes the 29th of February and the 31st of short months.
        dy = $urandom_range(3, 0) == 0 ? 0 : $urandom_range(99, month_days(mon) + 1);
        compose_timestamp();
      end
      3: begin
        hr = $urandom_range(99, 24);
        compose_timestamp();
      end
      4: begin
        if ($urandom_range(1, 0)) mnt = $urandom_range(99, 60);
        else sec = $urandom_range(99, 60);
        compose_timestamp();
      end
      5: str_len = $urandom_range(25, 1);
      6: begin
        n = $urandom_range(20, 1);
        repeat (n) begin
          str_buf[str_len] = $urandom_range(1, 0) ? 8'(CharZero + $urandom_range(9, 0))
                                                  : 8'($urandom_range(255, 0));
          str_len++;
        end
      end
      7: begin
        case ($urandom_range(5, 0))
          0: pos = int'(PosDash0);
          1: pos = int'(PosDash1);
          2: pos = int'(PosColon0);
          3: pos = int'(PosColon1);
          4: pos = int'(PosDot);
          default: pos = int'(PosTee);
        endcase
        case ($urandom_range(3, 0))
          0: str_buf[pos] = CharDash;
          1: str_buf[pos] = CharColon;
          2: str_buf[pos] = CharDot;
          default: str_buf[pos] = 8'($urandom_range(255, 0));
        endcase
      end
      default: begin
        do begin
          pos = $urandom_range(25, 0);
        end while (pos == int'(PosDash0) || pos == int'(PosDash1) || pos == int'(PosTee) ||
                   pos == int'(PosColon0) || pos == int'(PosColon1) ||
                   pos == int'(PosDot));
        str_buf[pos] = $urandom_range(1, 0) ? 8'($urandom_range(47, 0))
                                            : 8'($urandom_range(255, 58));
      end
    endcase
  endtask

  task automatic draw_noise();
    str_len = $urandom_range(40, 1);
    for (int i = 0; i < str_len; i++) begin
      case ($urandom_range(3, 0))
        0: str_buf[i] = 8'(CharZero + $urandom_range(9, 0));
        1: str_buf[i] = $urandom_range(1, 0) ? CharDash : CharColon;
        2: str_buf[i] = CharDot;
        default: str_buf[i] = 8'($urandom_range(255, 0));
      endcase
    end
  endtask

  task automatic queue_string(input bit drain, input bit calm);
    text_beat_t b;
    for (int i = 0; i < str_len; i++) begin
      b.ch    = str_buf[i];
      b.last  = (i == str_len - 1);
      b.gap   = calm ? 0 : $urandom_range(7, 0);
      b.drain = drain && (i == 0);
      beat_q.push_back(b);
    end
    queued_beats += str_len;
    strings_built++;
  endtask

  // Driver: one transaction per queued byte, with a drawn gap after each.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      hold_cnt = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        bytes_taken++;
        if (advance_checker(text_byte_i, is_last_i, verdict)) begin
          verdict_q.push_back(verdict);
          if (verdict) good_verdicts++;
          else bad_verdicts++;
        end
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (hold_cnt != 0) begin
          hold_cnt--;
          in_valid_i <= 1'b0;
        end else if (beat_q.size() != 0 &&
                     !(beat_q[0].drain && verdict_q.size() != 0)) begin
          beat = beat_q.pop_front();
          in_valid_i  <= 1'b1;
          text_byte_i <= beat.ch;
          is_last_i   <= beat.last;
          hold_cnt = beat.gap;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction and stalls at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_cnt = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (verdict_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected: expected none, actual format_ok=%0b",
                   $time, format_ok_o);
        end else begin
          want = verdict_q.pop_front();
          if (format_ok_o !== want) begin
            mismatches++;
            $display("%0t: format_ok mismatch: expected %0b, actual %0b",
                     $time, want, format_ok_o);
          end
        end
        if (results_seen % 16 == 0) calm_rx = ($urandom_range(2, 0) == 0);
        stall_cnt = calm_rx ? 0 : $urandom_range(7, 0);
      end
      if (stall_cnt != 0) begin
        stall_cnt--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    int spoil_kind;
    int pick_kind;
    spoil_kind = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Largest value of every field, then a lone byte that the sender holds back
    // until the first verdict has been returned.
    yr = 9999; mon = 12; dy = 31; hr = 23; mnt = 59; sec = 59; frac = 999999;
    compose_timestamp();
    queue_string(1'b0, 1'b0);
    str_buf[0] = CharNine;
    str_len = 1;
    queue_string(1'b1, 1'b0);

    while (queued_beats < 1050) begin
      pick_kind = $urandom_range(19, 0);
      if (pick_kind < 8) begin
        draw_timestamp();
      end else if (pick_kind < 16) begin
        draw_timestamp();
        spoil_timestamp(spoil_kind % 9);
        spoil_kind++;
      end else begin
        draw_noise();
      end
      queue_string($urandom_range(15, 0) == 0, $urandom_range(3, 0) == 0);
    end

    wait (bytes_taken == queued_beats);
    wait (verdict_q.size() == 0);
    repeat (8) @(posedge clk_i);
    $display("Sent %0d strings in %0d byte transactions; %0d verdicts checked.",
             strings_built, bytes_taken, results_seen);
    $display("Expected %0d well-formed and %0d malformed strings; %0d mismatches.",
             good_verdicts, bad_verdicts, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d of %0d bytes taken and %0d verdicts outstanding.",
             bytes_taken, queued_beats, verdict_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: timestamp_string_validator.f
design/tsv_pkg.sv
design/tsv_input_stage.sv
design/tsv_check_core.sv
design/tsv_output_stage.sv
design/timestamp_string_validator.sv
design/tsv_props.sv
dv/timestamp_string_validator_tb.sv
